// ===== rtl/ecpc_pkg.sv =====
// Shared types, constants and register codes of the escape count pixel colorizer.
`default_nettype none

package ecpc_pkg;

    // Field and storage widths.
    localparam int COUNT_W    = 16;
    localparam int IDX_W      = 8;
    localparam int COLOR_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Palette memory.
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    // Remainder pipeline: four quotient bits are resolved in each stage.
    localparam int DIV_GROUP  = 4;
    localparam int DIV_STAGES = COUNT_W / DIV_GROUP;

    // Register stages between the input and the output register.
    localparam int PIPE_DEPTH = DIV_STAGES + 2;

    // Hue arithmetic. A hue is at most five counts plus the offset.
    localparam int HUE_W         = COUNT_W + 3;
    localparam int Q_W           = HUE_W - 5;
    localparam int RECIP60_W     = 13;
    localparam int RECIP60_SHIFT = 18;
    localparam int RECIP6_W      = 14;
    localparam int RECIP6_SHIFT  = 16;
    localparam int SECTOR_W      = 3;
    localparam int REM60_W       = 6;

    localparam logic [RECIP60_W-1:0] RECIP60      = RECIP60_W'(4369);
    localparam logic [RECIP6_W-1:0]  RECIP6       = RECIP6_W'(10922);
    localparam logic [5:0]           SECTOR_SPAN  = 6'd60;
    localparam logic [2:0]           SECTOR_COUNT = 3'd6;
    localparam logic [COLOR_W-1:0]   FULL         = 8'd255;

    // Hue wheel sectors.
    localparam logic [SECTOR_W-1:0] SECT_RED_UP   = 3'd0;
    localparam logic [SECTOR_W-1:0] SECT_RED_DN   = 3'd1;
    localparam logic [SECTOR_W-1:0] SECT_BLUE_UP  = 3'd2;
    localparam logic [SECTOR_W-1:0] SECT_GREEN_DN = 3'd3;
    localparam logic [SECTOR_W-1:0] SECT_RED_UP2  = 3'd4;

    // Item commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET   = 2'd2;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] load_red;
        logic [COLOR_W-1:0] load_green;
        logic [COLOR_W-1:0] load_blue;
        logic [COUNT_W-1:0] escape_count;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_red;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_blue;
    } out_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

// ===== rtl/escape_count_pixel_colorizer.sv =====
// Top level of the escape count pixel colorizer: configuration, pipeline control, output.
//
// Items enter on in_item under in_valid / in_stall and leave on out_item under
// out_valid / out_stall; a transfer happens at a clock edge with valid high and
// stall low. A load item writes one palette entry and gives no result; a pixel
// item gives exactly one result, in order.
// Configuration registers are written over cfg_valid / cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high. Write them only while no item is in
// flight.
// Pipeline: a pixel accepted at an edge loads the first of six pipeline stages
// (the four-stage remainder pipeline, then the palette memory address and read
// stages); the output register that follows drives out_valid.
// Throughput: one item per clock while the output is not stalled.
// Reset clears the configuration to hue mode, size 2, offset 0, and empties the
// pipeline. Palette contents are undefined until loaded.
// While a result waits on a stalled output, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
`default_nettype none

module escape_count_pixel_colorizer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire ecpc_pkg::in_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output ecpc_pkg::out_item_t                      out_item,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ecpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ecpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PD = ecpc_pkg::PIPE_DEPTH;

    logic                            mode_reg;
    logic [ecpc_pkg::SIZE_W-1:0]     size_reg;
    logic [ecpc_pkg::OFFSET_W-1:0]   offset_reg;

    logic                            vld_reg [PD];
    logic                            out_valid_reg;
    ecpc_pkg::out_item_t             out_reg;

    logic                            en;
    logic                            take;
    ecpc_pkg::rgb_t                  pal_color;
    ecpc_pkg::rgb_t                  hue_color;
    ecpc_pkg::rgb_t                  sel_color;

    // The pipeline advances unless a finished result sits in a stalled output register.
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign take      = in_valid && en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= 1'b0;
            size_reg   <= ecpc_pkg::SIZE_W'(2);
            offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ecpc_pkg::CFG_PALETTE_MODE: mode_reg   <= cfg_data[0];
                ecpc_pkg::CFG_PALETTE_SIZE: size_reg   <= cfg_data[ecpc_pkg::SIZE_W-1:0];
                ecpc_pkg::CFG_HUE_OFFSET:   offset_reg <= cfg_data[ecpc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    ecpc_palette_path u_palette (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .take         (take),
        .item         (in_item),
        .palette_size (size_reg),
        .color        (pal_color)
    );

    ecpc_hue_path u_hue (
        .clk          (clk),
        .en           (en),
        .escape_count (in_item.escape_count),
        .hue_offset   (offset_reg),
        .color        (hue_color)
    );

    assign sel_color = mode_reg ? pal_color : hue_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < PD; s++) begin
                vld_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= take && (in_item.command == ecpc_pkg::CMD_PIXEL);
            for (int s = 1; s < PD; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_valid_reg <= vld_reg[PD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[PD-1]) begin
            out_reg <= '{pixel_red:   sel_color.red,
                         pixel_green: sel_color.green,
                         pixel_blue:  sel_color.blue};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/ecpc_palette_path.sv =====
// Palette path: pipelined count remainder, entry selection and the palette memory.
`default_nettype none

module ecpc_palette_path (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             take,
    input  wire ecpc_pkg::in_item_t               item,
    input  wire logic [ecpc_pkg::SIZE_W-1:0]      palette_size,
    output ecpc_pkg::rgb_t                        color
);

    localparam int NS = ecpc_pkg::DIV_STAGES;
    localparam int AW = ecpc_pkg::PAL_AW;
    localparam int CW = ecpc_pkg::COUNT_W;
    localparam int GW = ecpc_pkg::DIV_GROUP;
    localparam int SW = ecpc_pkg::SIZE_W;

    // Restoring remainder over one group of count bits, most significant first.
    function automatic logic [AW-1:0] div_group(input logic [AW-1:0] rem,
                                                input logic [GW-1:0] bits,
                                                input logic [AW-1:0] dvs);
        logic [AW:0]   wide;
        logic [AW-1:0] acc;
        acc = rem;
        for (int i = GW - 1; i >= 0; i--) begin
            wide = {acc, bits[i]};
            if (wide >= {1'b0, dvs}) begin
                wide = wide - {1'b0, dvs};
            end
            acc = wide[AW-1:0];
        end
        return acc;
    endfunction

    logic [SW-1:0] size_c;
    logic [SW-1:0] dvs_w;
    logic [AW-1:0] dvs;
    logic          ld_in;

    logic [AW-1:0]                  rem_reg  [NS];
    logic [CW-1:0]                  cnt_reg  [NS];
    logic                           zero_reg [NS];
    logic [ecpc_pkg::IDX_W-1:0]     idx_reg  [NS];
    ecpc_pkg::rgb_t                 ldc_reg  [NS];
    logic                           ld_reg   [NS];

    logic [AW-1:0]   addr_reg;
    ecpc_pkg::rgb_t  wdata_reg;
    logic            wr_reg;
    ecpc_pkg::rgb_t  rd_reg;
    ecpc_pkg::rgb_t  mem [ecpc_pkg::PAL_DEPTH];

    always_comb
    begin
        if (palette_size < SW'(2)) begin
            size_c = SW'(2);
        end else if (palette_size > SW'(ecpc_pkg::PAL_DEPTH)) begin
            size_c = SW'(ecpc_pkg::PAL_DEPTH);
        end else begin
            size_c = palette_size;
        end
        dvs_w = size_c - SW'(1);
        dvs   = dvs_w[AW-1:0];
    end

    // Loads aimed past the end of the store are dropped here.
    assign ld_in = take && (item.command == ecpc_pkg::CMD_LOAD) &&
                   ({1'b0, item.entry_index} < (ecpc_pkg::IDX_W + 1)'(ecpc_pkg::PAL_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < NS; s++) begin
                ld_reg[s] <= 1'b0;
            end
            wr_reg <= 1'b0;
        end else if (en) begin
            ld_reg[0] <= ld_in;
            for (int s = 1; s < NS; s++) begin
                ld_reg[s] <= ld_reg[s-1];
            end
            wr_reg <= ld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rem_reg[0]  <= div_group('0, item.escape_count[CW-1 -: GW], dvs);
            cnt_reg[0]  <= item.escape_count;
            zero_reg[0] <= (item.escape_count == '0);
            idx_reg[0]  <= item.entry_index;
            ldc_reg[0]  <= '{red: item.load_red, green: item.load_green, blue: item.load_blue};
            for (int s = 1; s < NS; s++) begin
                rem_reg[s]  <= div_group(rem_reg[s-1], cnt_reg[s-1][CW-1-s*GW -: GW], dvs);
                cnt_reg[s]  <= cnt_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                idx_reg[s]  <= idx_reg[s-1];
                ldc_reg[s]  <= ldc_reg[s-1];
            end

            // Loads write and pixels read at the same stage, so order is kept.
            if (ld_reg[NS-1]) begin
                addr_reg <= idx_reg[NS-1][AW-1:0];
            end else if (zero_reg[NS-1]) begin
                addr_reg <= '0;
            end else begin
                addr_reg <= rem_reg[NS-1] + AW'(1);
            end
            wdata_reg <= ldc_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            if (wr_reg) begin
                mem[addr_reg] <= wdata_reg;
            end
            rd_reg <= mem[addr_reg];
        end
    end

    assign color = rd_reg;

endmodule

`default_nettype wire

// ===== rtl/ecpc_hue_path.sv =====
// Hue path: hue from the count, sector and ramp by reciprocal multiply, wheel color.
`default_nettype none

module ecpc_hue_path (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [ecpc_pkg::COUNT_W-1:0]     escape_count,
    input  wire logic [ecpc_pkg::OFFSET_W-1:0]    hue_offset,
    output ecpc_pkg::rgb_t                        color
);

    localparam int HW  = ecpc_pkg::HUE_W;
    localparam int QW  = ecpc_pkg::Q_W;
    localparam int RW  = ecpc_pkg::REM60_W;
    localparam int SW  = ecpc_pkg::SECTOR_W;
    localparam int P1W = HW + ecpc_pkg::RECIP60_W;
    localparam int P2W = QW + ecpc_pkg::RECIP6_W;
    localparam int Q6W = P2W - ecpc_pkg::RECIP6_SHIFT;
    localparam int CLW = ecpc_pkg::COLOR_W;

    // Stage 1: hue.
    logic [HW-1:0]  hue1_reg;
    logic           zero1_reg;
    // Stage 2: estimated hue / 60, never above the true quotient and at most one below.
    logic [QW-1:0]  qe2_reg;
    logic [HW-1:0]  hue2_reg;
    logic           zero2_reg;
    // Stage 3: exact quotient and remainder by 60.
    logic [QW-1:0]  q3_reg;
    logic [RW-1:0]  rem3_reg;
    logic           zero3_reg;
    // Stage 4: estimated quotient / 6.
    logic [Q6W-1:0] q6e4_reg;
    logic [QW-1:0]  q4_reg;
    logic [RW-1:0]  rem4_reg;
    logic           zero4_reg;
    // Stage 5: sector and ramps.
    logic [SW-1:0]  sect5_reg;
    logic [CLW-1:0] up5_reg;
    logic [CLW-1:0] down5_reg;
    logic           zero5_reg;
    // Stage 6: wheel color.
    ecpc_pkg::rgb_t color6_reg;

    logic [P1W-1:0] prod1;
    logic [HW-1:0]  diff3;
    logic [HW-1:0]  adj3;
    logic [P2W-1:0] prod2;
    logic [QW-1:0]  diff5;
    logic [QW-1:0]  adj5;
    logic [10:0]    ramp17;
    ecpc_pkg::rgb_t wheel;

    always_comb
    begin
        prod1  = P1W'(hue1_reg) * P1W'(ecpc_pkg::RECIP60);
        diff3  = hue2_reg - HW'(qe2_reg) * HW'(ecpc_pkg::SECTOR_SPAN);
        adj3   = diff3 - HW'(ecpc_pkg::SECTOR_SPAN);
        prod2  = P2W'(q3_reg) * P2W'(ecpc_pkg::RECIP6);
        diff5  = q4_reg - QW'(q6e4_reg) * QW'(ecpc_pkg::SECTOR_COUNT);
        adj5   = diff5 - QW'(ecpc_pkg::SECTOR_COUNT);
        // 255 / 60 is exactly 17 / 4.
        ramp17 = {1'b0, rem4_reg, 4'b0000} + 11'(rem4_reg);
    end

    always_comb
    begin
        wheel = '0;
        case (sect5_reg)
            ecpc_pkg::SECT_RED_UP:   wheel = '{red: ecpc_pkg::FULL, green: up5_reg, blue: '0};
            ecpc_pkg::SECT_RED_DN:   wheel = '{red: down5_reg, green: ecpc_pkg::FULL, blue: '0};
            ecpc_pkg::SECT_BLUE_UP:  wheel = '{red: '0, green: ecpc_pkg::FULL, blue: up5_reg};
            ecpc_pkg::SECT_GREEN_DN: wheel = '{red: '0, green: down5_reg, blue: ecpc_pkg::FULL};
            ecpc_pkg::SECT_RED_UP2:  wheel = '{red: up5_reg, green: '0, blue: ecpc_pkg::FULL};
            default:                 wheel = '{red: ecpc_pkg::FULL, green: '0, blue: down5_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            hue1_reg  <= HW'({escape_count, 2'b00}) + HW'(escape_count) + HW'(hue_offset);
            zero1_reg <= (escape_count == '0);

            qe2_reg   <= prod1[P1W-1:ecpc_pkg::RECIP60_SHIFT];
            hue2_reg  <= hue1_reg;
            zero2_reg <= zero1_reg;

            if (diff3 >= HW'(ecpc_pkg::SECTOR_SPAN)) begin
                q3_reg   <= qe2_reg + QW'(1);
                rem3_reg <= adj3[RW-1:0];
            end else begin
                q3_reg   <= qe2_reg;
                rem3_reg <= diff3[RW-1:0];
            end
            zero3_reg <= zero2_reg;

            q6e4_reg  <= prod2[P2W-1:ecpc_pkg::RECIP6_SHIFT];
            q4_reg    <= q3_reg;
            rem4_reg  <= rem3_reg;
            zero4_reg <= zero3_reg;

            if (diff5 >= QW'(ecpc_pkg::SECTOR_COUNT)) begin
                sect5_reg <= adj5[SW-1:0];
            end else begin
                sect5_reg <= diff5[SW-1:0];
            end
            up5_reg   <= ramp17[9:2];
            down5_reg <= ecpc_pkg::FULL - ramp17[9:2];
            zero5_reg <= zero4_reg;

            color6_reg <= zero5_reg ? '0 : wheel;
        end
    end

    assign color = color6_reg;

endmodule

`default_nettype wire
